>>> sv/dll_pkg.sv
// shared types and constants of the doubly linked list manager
`default_nettype none
package dll_pkg;
  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;
  localparam int LINK_BITS  = $clog2(CAPACITY + 1);
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = 6;

  localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(CAPACITY);

  localparam logic [2:0] CMD_INS_HEAD  = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL  = 3'd1;
  localparam logic [2:0] CMD_INS_AFTER = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD  = 3'd3;
  localparam logic [2:0] CMD_DEL_TAIL  = 3'd4;
  localparam logic [2:0] CMD_DEL_VAL   = 3'd5;
  localparam logic [2:0] CMD_DUMP      = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] match_key;
    logic [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_value;
    logic        last;
    logic [5:0]  element_count;
  } res_t;

  // one memory access request from the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_BITS-1:0]   addr;
    logic                  wr_val;
    logic [VALUE_BITS-1:0] val;
    logic                  wr_next;
    logic [LINK_BITS-1:0]  next;
    logic                  wr_prev;
    logic [LINK_BITS-1:0]  prev;
  } mem_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic [LINK_BITS-1:0]  next;
    logic [LINK_BITS-1:0]  prev;
  } node_t;

  function automatic logic [VALUE_BITS-1:0] to_value(input logic [31:0] f);
    return VALUE_BITS'(signed'(f));
  endfunction

  function automatic logic [31:0] to_out(input logic [VALUE_BITS-1:0] v);
    return 32'(signed'(v));
  endfunction
endpackage
`default_nettype wire

>>> sv/dll_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none
interface dll_cmd_if;
  logic           valid;
  logic           ready;
  dll_pkg::cmd_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dll_res_if;
  logic           valid;
  logic           ready;
  dll_pkg::res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/doubly_linked_list_manager.sv
// doubly linked list manager: top level
// status-only results are registered from the command transfer; head/tail inserts
// and deletes read a node or the free head, then write in S_W1, S_W2 and S_W3;
// searches read one node at a time; a dump offers one value per node, held while stalled
// one command at a time: a command is taken only in idle with no result pending
// reset: synchronous, then the free list is built, no transfer taken
`default_nettype none
module doubly_linked_list_manager (
  input  wire logic clk,
  input  wire logic rst_n,
  dll_cmd_if.sink   in_ch,
  dll_res_if.source out_ch
);
  logic init_we;
  logic [dll_pkg::IDX_BITS-1:0] init_addr;
  dll_pkg::mem_req_t req;
  dll_pkg::node_t    rd;

  dll_seq u_seq (
    .clk, .rst_n, .cmd_ch(in_ch), .res_ch(out_ch),
    .init_we, .init_addr, .req, .rd
  );

  dll_node_mem u_mem (
    .clk, .rst_n, .init_we, .init_addr, .req, .rd
  );
endmodule
`default_nettype wire

>>> sv/dll_node_mem.sv
// node pool memory: values and both link arrays, one access port plus an init write for the free list
`default_nettype none
module dll_node_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              init_we,
  input  wire logic [dll_pkg::IDX_BITS-1:0] init_addr,
  input  wire dll_pkg::mem_req_t req,
  output dll_pkg::node_t         rd
);
  logic [dll_pkg::VALUE_BITS-1:0] val_mem  [dll_pkg::CAPACITY];
  logic [dll_pkg::LINK_BITS-1:0]  next_mem [dll_pkg::CAPACITY];
  logic [dll_pkg::LINK_BITS-1:0]  prev_mem [dll_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd <= '0;
    end else if (init_we) begin
      next_mem[init_addr] <= dll_pkg::LINK_BITS'(init_addr) + 1'b1;
    end else begin
      if (req.we && req.wr_val)  val_mem[req.addr]  <= req.val;
      if (req.we && req.wr_next) next_mem[req.addr] <= req.next;
      if (req.we && req.wr_prev) prev_mem[req.addr] <= req.prev;
      if (!req.we) begin
        rd.val  <= val_mem[req.addr];
        rd.next <= next_mem[req.addr];
        rd.prev <= prev_mem[req.addr];
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/dll_seq.sv
// command sequencer: walks and relinks the list through the node memory
`default_nettype none
module dll_seq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dll_cmd_if.sink         cmd_ch,
  dll_res_if.source       res_ch,
  output logic            init_we,
  output logic [dll_pkg::IDX_BITS-1:0] init_addr,
  output dll_pkg::mem_req_t req,
  input  wire dll_pkg::node_t rd
);
  localparam int LB = dll_pkg::LINK_BITS;
  localparam int IB = dll_pkg::IDX_BITS;
  localparam int VB = dll_pkg::VALUE_BITS;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;  // issue read of cur_r
  localparam logic [3:0] S_WAIT  = 4'd3;  // read data arrives
  localparam logic [3:0] S_W1    = 4'd4;
  localparam logic [3:0] S_W2    = 4'd5;
  localparam logic [3:0] S_W3    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_FREE  = 4'd8;  // read free head's next
  localparam logic [3:0] S_FWAIT = 4'd9;  // free head's next arrives

  logic [3:0]    state_r, state_nxt;
  logic [LB-1:0] head_r, tail_r, free_r, cur_r, n_r, p_r, q_r;
  logic [5:0]    cnt_r;
  logic [5:0]    steps_r;
  logic [IB-1:0] init_r;
  logic [2:0]    cmd_r;
  logic [VB-1:0] key_r, val_r;
  logic          res_valid_r;
  dll_pkg::res_t res_r;

  logic nx_ok, fin;
  assign nx_ok  = rd.next < dll_pkg::NIL_LINK;
  assign fin    = !nx_ok || (steps_r == 6'(dll_pkg::CAPACITY - 1));

  assign init_we   = state_r == S_INIT;
  assign init_addr = init_r;
  assign cmd_ch.ready  = state_r == S_IDLE && !res_valid_r;
  assign res_ch.valid  = res_valid_r;
  assign res_ch.payload = res_r;

  always_comb begin
    req = '0;
    req.addr = cur_r[IB-1:0];
    unique case (state_r)
      S_W1, S_W2, S_W3: begin
        req.we = 1'b1;
      end
      default: ;
    endcase
    // write steps per command
    if (state_r == S_W1) begin
      req.addr = n_r[IB-1:0];
      req.wr_val = cmd_r <= dll_pkg::CMD_INS_AFTER;
      req.val = val_r;
      req.wr_next = 1'b1;
      req.wr_prev = 1'b1;
      unique case (cmd_r)
        dll_pkg::CMD_INS_HEAD: begin
          req.next = head_r; req.prev = dll_pkg::NIL_LINK;
        end
        dll_pkg::CMD_INS_TAIL: begin
          req.next = dll_pkg::NIL_LINK; req.prev = tail_r;
        end
        dll_pkg::CMD_INS_AFTER: begin
          req.next = q_r; req.prev = p_r;
        end
        default: begin  // delete: return node to free list
          req.next = free_r; req.prev = dll_pkg::NIL_LINK;
        end
      endcase
    end else if (state_r == S_W2) begin
      // fix predecessor's next link
      req.we = p_r != dll_pkg::NIL_LINK;
      req.addr = p_r[IB-1:0];
      req.wr_next = 1'b1;
      req.next = (cmd_r <= dll_pkg::CMD_INS_AFTER) ? n_r : q_r;
    end else if (state_r == S_W3) begin
      // fix successor's prev link
      req.we = q_r != dll_pkg::NIL_LINK;
      req.addr = q_r[IB-1:0];
      req.wr_prev = 1'b1;
      req.prev = (cmd_r <= dll_pkg::CMD_INS_AFTER) ? n_r : p_r;
    end else if (state_r == S_FREE) begin
      req.addr = free_r[IB-1:0];
    end
  end

  logic [LB-1:0] head_nxt, tail_nxt, free_nxt, cur_nxt, n_nxt, p_nxt, q_nxt;
  logic [5:0]    cnt_nxt, steps_nxt;
  logic          res_valid_nxt, emit;
  dll_pkg::res_t res_nxt;
  logic [1:0]    st;

  always_comb begin
    state_nxt = state_r; head_nxt = head_r; tail_nxt = tail_r; free_nxt = free_r;
    cur_nxt = cur_r; n_nxt = n_r; p_nxt = p_r; q_nxt = q_r; cnt_nxt = cnt_r;
    steps_nxt = steps_r; res_valid_nxt = res_valid_r; res_nxt = res_r;
    emit = 1'b0; st = dll_pkg::ST_OK;
    if (res_valid_r && res_ch.ready) res_valid_nxt = 1'b0;
    unique case (state_r)
      S_INIT: begin
        if (init_r == IB'(dll_pkg::CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_ch.valid && cmd_ch.ready) begin
          steps_nxt = '0;
          cur_nxt = head_r;
          unique case (cmd_ch.payload.cmd)
            dll_pkg::CMD_INS_HEAD, dll_pkg::CMD_INS_TAIL: begin
              if (free_r == dll_pkg::NIL_LINK) begin
                emit = 1'b1; st = dll_pkg::ST_FULL;
              end else begin
                n_nxt = free_r;
                if (cmd_ch.payload.cmd == dll_pkg::CMD_INS_HEAD) begin
                  p_nxt = dll_pkg::NIL_LINK; q_nxt = head_r;
                end else begin
                  p_nxt = tail_r; q_nxt = dll_pkg::NIL_LINK;
                end
                state_nxt = S_FREE;
              end
            end
            dll_pkg::CMD_INS_AFTER: begin
              if (free_r == dll_pkg::NIL_LINK) begin
                emit = 1'b1; st = dll_pkg::ST_FULL;
              end else if (head_r == dll_pkg::NIL_LINK) begin
                emit = 1'b1; st = dll_pkg::ST_NOTFOUND;
              end else state_nxt = S_RD;
            end
            dll_pkg::CMD_DEL_HEAD, dll_pkg::CMD_DEL_TAIL, dll_pkg::CMD_DEL_VAL: begin
              if (head_r == dll_pkg::NIL_LINK) begin
                emit = 1'b1; st = dll_pkg::ST_EMPTY;
              end else begin
                if (cmd_ch.payload.cmd == dll_pkg::CMD_DEL_TAIL) cur_nxt = tail_r;
                state_nxt = S_RD;
              end
            end
            dll_pkg::CMD_DUMP: begin
              if (head_r == dll_pkg::NIL_LINK) begin
                emit = 1'b1; st = dll_pkg::ST_EMPTY;
              end else state_nxt = S_RD;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_RD: state_nxt = S_WAIT;
      S_WAIT: begin
        unique case (cmd_r)
          dll_pkg::CMD_DUMP: begin
            if (!res_valid_r || res_ch.ready) begin
              res_valid_nxt = 1'b1;
              res_nxt.status = dll_pkg::ST_OK;
              res_nxt.out_value = dll_pkg::to_out(rd.val);
              res_nxt.last = fin;
              res_nxt.element_count = cnt_r;
              steps_nxt = steps_r + 6'd1;
              cur_nxt = rd.next;
              state_nxt = fin ? S_IDLE : S_RD;
            end
          end
          dll_pkg::CMD_INS_AFTER, dll_pkg::CMD_DEL_VAL: begin
            if (rd.val == ((cmd_r == dll_pkg::CMD_INS_AFTER) ? key_r : val_r)) begin
              if (cmd_r == dll_pkg::CMD_INS_AFTER) begin
                n_nxt = free_r; p_nxt = cur_r; q_nxt = rd.next;
                state_nxt = S_FREE;
              end else begin
                n_nxt = cur_r; p_nxt = rd.prev; q_nxt = rd.next;
                state_nxt = S_W1;
              end
            end else if (fin) begin
              emit = 1'b1; st = dll_pkg::ST_NOTFOUND; state_nxt = S_OUT;
            end else begin
              steps_nxt = steps_r + 6'd1;
              cur_nxt = rd.next;
              state_nxt = S_RD;
            end
          end
          default: begin  // delete head or tail
            n_nxt = cur_r; p_nxt = rd.prev; q_nxt = rd.next;
            state_nxt = S_W1;
          end
        endcase
      end
      S_FREE: state_nxt = S_FWAIT;
      S_FWAIT: begin
        free_nxt = rd.next;
        state_nxt = S_W1;
      end
      S_W1: begin
        if (cmd_r <= dll_pkg::CMD_INS_AFTER) cnt_nxt = cnt_r + 6'd1;
        else begin
          cnt_nxt = cnt_r - 6'd1;
          free_nxt = n_r;
        end
        state_nxt = S_W2;
      end
      S_W2: state_nxt = S_W3;
      S_W3: begin
        if (p_r == dll_pkg::NIL_LINK)
          head_nxt = (cmd_r <= dll_pkg::CMD_INS_AFTER) ? n_r : q_r;
        if (q_r == dll_pkg::NIL_LINK)
          tail_nxt = (cmd_r <= dll_pkg::CMD_INS_AFTER) ? n_r : p_r;
        emit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_valid_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
    if (emit) begin
      res_valid_nxt = 1'b1;
      res_nxt.status = st;
      res_nxt.out_value = '0;
      res_nxt.last = 1'b1;
      res_nxt.element_count = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; init_r <= '0;
      head_r <= dll_pkg::NIL_LINK; tail_r <= dll_pkg::NIL_LINK;
      free_r <= '0; cnt_r <= '0; res_valid_r <= 1'b0;
      cur_r <= '0; n_r <= '0; p_r <= dll_pkg::NIL_LINK; q_r <= '0;
      steps_r <= '0; cmd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) init_r <= init_r + 1'b1;
      head_r <= head_nxt; tail_r <= tail_nxt; free_r <= free_nxt; cnt_r <= cnt_nxt;
      res_valid_r <= res_valid_nxt; cur_r <= cur_nxt; n_r <= n_nxt;
      p_r <= p_nxt; q_r <= q_nxt; steps_r <= steps_nxt;
      if (state_r == S_IDLE) cmd_r <= cmd_ch.payload.cmd;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE) begin
      key_r <= dll_pkg::to_value(cmd_ch.payload.match_key);
      val_r <= dll_pkg::to_value(cmd_ch.payload.item_value);
    end
  end
endmodule
`default_nettype wire

>>> sv/dll_checker.sv
// port-level checks for the doubly linked list manager
`default_nettype none
module dll_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire dll_pkg::res_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.element_count <= 6'(dll_pkg::CAPACITY)) else $error("count overflow");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.status != dll_pkg::ST_OK |-> out_payload.last
    && out_payload.out_value == '0) else $error("bad status result");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("took two commands");
endmodule

bind doubly_linked_list_manager dll_props u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire

>>> dv/dll_checker.sv
// checker: predicts list manager results and compares them with the block output
`timescale 1ns / 100ps
`default_nettype none
module dll_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire dll_pkg::cmd_t in_payload,
  input  wire logic          out_valid,
  input  wire logic          out_ready,
  input  wire dll_pkg::res_t out_payload,
  output int                 fail_count,
  output int                 pending
);
  localparam int CAP = dll_pkg::CAPACITY;

  logic [31:0]   node_val [CAP];
  int            node_next [CAP];
  int            node_prev [CAP];
  int            head_idx, tail_idx, free_idx, used;
  dll_pkg::res_t expected_q [$];

  assign pending = expected_q.size();

  function automatic int find_value(logic [31:0] v);
    int n;
    n = head_idx;
    for (int s = 0; s < CAP && n < CAP; s++) begin
      if (node_val[n] == v) return n;
      n = node_next[n];
    end
    return CAP;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [31:0] v, logic lst);
    dll_pkg::res_t r;
    r.status = st;
    r.out_value = v;
    r.last = lst;
    r.element_count = 6'(used);
    expected_q.push_back(r);
  endfunction

  task automatic apply_command(dll_pkg::cmd_t c);
    int n, t, p, q;
    logic [1:0] st;
    st = dll_pkg::ST_OK;
    case (c.cmd)
      dll_pkg::CMD_INS_HEAD, dll_pkg::CMD_INS_TAIL, dll_pkg::CMD_INS_AFTER: begin
        t = CAP;
        if (free_idx >= CAP) st = dll_pkg::ST_FULL;
        else begin
          if (c.cmd == dll_pkg::CMD_INS_AFTER) t = find_value(c.match_key);
          if (c.cmd == dll_pkg::CMD_INS_AFTER && t >= CAP) st = dll_pkg::ST_NOTFOUND;
          else begin
            n = free_idx;
            free_idx = node_next[n];
            used++;
            node_val[n] = c.item_value;
            if (c.cmd == dll_pkg::CMD_INS_HEAD) begin
              node_prev[n] = CAP;
              node_next[n] = head_idx;
              if (head_idx < CAP) node_prev[head_idx] = n;
              else tail_idx = n;
              head_idx = n;
            end else if (c.cmd == dll_pkg::CMD_INS_TAIL) begin
              node_next[n] = CAP;
              node_prev[n] = tail_idx;
              if (tail_idx < CAP) node_next[tail_idx] = n;
              else head_idx = n;
              tail_idx = n;
            end else begin
              q = node_next[t];
              node_prev[n] = t;
              node_next[n] = q;
              if (q < CAP) node_prev[q] = n;
              else tail_idx = n;
              node_next[t] = n;
            end
          end
        end
        push_result(st, '0, 1'b1);
      end
      dll_pkg::CMD_DEL_HEAD, dll_pkg::CMD_DEL_TAIL, dll_pkg::CMD_DEL_VAL: begin
        if (head_idx >= CAP) st = dll_pkg::ST_EMPTY;
        else begin
          if (c.cmd == dll_pkg::CMD_DEL_HEAD) n = head_idx;
          else if (c.cmd == dll_pkg::CMD_DEL_TAIL) n = tail_idx;
          else n = find_value(c.item_value);
          if (n >= CAP) st = dll_pkg::ST_NOTFOUND;
          else begin
            p = node_prev[n];
            q = node_next[n];
            if (p < CAP) node_next[p] = q;
            else head_idx = q;
            if (q < CAP) node_prev[q] = p;
            else tail_idx = p;
            node_next[n] = free_idx;
            node_prev[n] = CAP;
            free_idx = n;
            if (used > 0) used--;
          end
        end
        push_result(st, '0, 1'b1);
      end
      dll_pkg::CMD_DUMP: begin
        n = head_idx;
        if (n >= CAP) push_result(dll_pkg::ST_EMPTY, '0, 1'b1);
        for (int s = 0; s < CAP && n < CAP; s++) begin
          q = node_next[n];
          push_result(dll_pkg::ST_OK, node_val[n], (q >= CAP) || (s + 1 == CAP));
          n = q;
        end
      end
      default: push_result(dll_pkg::ST_OK, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    dll_pkg::res_t e;
    if (!rst_n) begin
      for (int i = 0; i < CAP; i++) begin
        node_val[i] = '0;
        node_next[i] = i + 1;
        node_prev[i] = CAP;
      end
      head_idx = CAP;
      tail_idx = CAP;
      free_idx = 0;
      used = 0;
      fail_count <= 0;
    end else begin
      // results first: a result never belongs to the command taken in the same edge
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer %p", out_payload);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_payload.status !== e.status)
            $error("status expected %0d actual %0d", e.status, out_payload.status);
          if (out_payload.out_value !== e.out_value)
            $error("out_value expected %0d actual %0d", $signed(e.out_value),
                   $signed(out_payload.out_value));
          if (out_payload.last !== e.last)
            $error("last expected %0d actual %0d", e.last, out_payload.last);
          if (out_payload.element_count !== e.element_count)
            $error("element_count expected %0d actual %0d", e.element_count,
                   out_payload.element_count);
          if (out_payload !== e) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && in_ready) apply_command(in_payload);
    end
  end
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// testbench top: clock, reset, command stimulus, result stalls and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_count, pending, idle_cycles;
  logic hold_off;
  logic stim_done;

  dll_cmd_if in_ch ();
  dll_res_if out_ch ();

  doubly_linked_list_manager dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  dll_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_payload(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  logic [31:0] pool_vals [$];

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 7));
    if (r < 7 && pool_vals.size() > 0) return pool_vals[$urandom_range(0, pool_vals.size() - 1)];
    if (r == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  // valid stays high after a transfer until the next item or a drain
  task automatic send_cmd(logic [2:0] c, logic [31:0] k, logic [31:0] v);
    int d;
    d = $urandom_range(0, 3);
    if (d > 0) begin
      in_ch.valid <= 1'b0;
      repeat (d) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{cmd: c, match_key: k, item_value: v};
    pool_vals.push_back(v);
    if (pool_vals.size() > 16) void'(pool_vals.pop_front());
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic random_cmd();
    int r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    if (r < 40) c = $urandom_range(0, 1) ? dll_pkg::CMD_INS_HEAD : dll_pkg::CMD_INS_TAIL;
    else if (r < 55) c = dll_pkg::CMD_INS_AFTER;
    else if (r < 65) c = dll_pkg::CMD_DEL_HEAD;
    else if (r < 72) c = dll_pkg::CMD_DEL_TAIL;
    else if (r < 88) c = dll_pkg::CMD_DEL_VAL;
    else if (r < 97) c = dll_pkg::CMD_DUMP;
    else c = CMD_UNUSED;
    send_cmd(c, pick_value(), pick_value());
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random wait per result, plus one long hold-off on request
  initial begin
    int d;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      d = $urandom_range(0, 3);
      if (d > 0) begin
        out_ch.ready <= 1'b0;
        repeat (d) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    stim_done = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, every command
    send_cmd(dll_pkg::CMD_DUMP, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_HEAD, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_TAIL, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_VAL, 0, 5);
    send_cmd(dll_pkg::CMD_INS_AFTER, 1, 2);
    send_cmd(dll_pkg::CMD_INS_HEAD, 0, 32'h8000_0000);
    send_cmd(dll_pkg::CMD_INS_TAIL, 32'hffff_ffff, 32'h7fff_ffff);
    send_cmd(dll_pkg::CMD_INS_AFTER, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(dll_pkg::CMD_INS_AFTER, 32'h7fff_ffff, 0);
    send_cmd(dll_pkg::CMD_INS_AFTER, 32'h1234_5678, 1);
    send_cmd(dll_pkg::CMD_DUMP, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_VAL, 0, 32'h5555_5555);
    send_cmd(dll_pkg::CMD_DEL_VAL, 0, 32'hffff_ffff);
    send_cmd(dll_pkg::CMD_DEL_HEAD, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_TAIL, 0, 0);
    send_cmd(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(dll_pkg::CMD_DUMP, 0, 0);
    send_cmd(dll_pkg::CMD_DEL_HEAD, 0, 0);
    send_cmd(dll_pkg::CMD_DUMP, 0, 0);

    // fill the pool past capacity, with a long result hold-off
    hold_off = 1'b1;
    for (int i = 0; i < 33; i++) send_cmd(dll_pkg::CMD_INS_TAIL, 0, i);
    send_cmd(dll_pkg::CMD_INS_AFTER, 32'h7777_7777, 9);
    send_cmd(dll_pkg::CMD_INS_HEAD, 0, 9);
    send_cmd(dll_pkg::CMD_DUMP, 0, 0);
    // sender pauses until every result is in
    wait_drained();
    for (int i = 0; i < 32; i++) send_cmd(dll_pkg::CMD_DEL_HEAD, 0, 0);

    for (int i = 0; i < 240; i++) begin
      random_cmd();
      if (i == 120) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire
